// ===== hdl/mtss_pkg.sv =====
// Shared types, constants and cell arithmetic for the multitrack step sequencer.
// No dependencies; every other file uses this package by scoped names.

package mtss_pkg;

  localparam int TRACKS_DEF = 4;
  localparam int STEPS_DEF  = 8;

  localparam int CMD_W   = 4;
  localparam int IDX_W   = 3;
  localparam int BASE_W  = 7;
  localparam int NOTE_W  = 8;
  localparam int VEL_W   = 5;
  localparam int PITCH_W = 4;
  localparam int OCT_W   = 4;
  localparam int MODE_W  = 2;
  localparam int SUM_W   = 10;

  localparam logic [CMD_W-1:0] CMD_SELECT    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INC       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_DEC       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT_TRK  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_PREV_TRK  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_NEXT_MODE = 4'd6;
  localparam logic [CMD_W-1:0] CMD_PREV_MODE = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PLAY      = 4'd8;

  localparam logic [MODE_W-1:0] MODE_PITCH    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OCTAVE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VELOCITY = 2'd2;

  localparam logic [PITCH_W-1:0]       PITCH_MAX  = 4'd11;
  localparam logic signed [OCT_W-1:0]  OCT_MIN    = -4'sd5;
  localparam logic signed [OCT_W-1:0]  OCT_MAX    = 4'sd5;
  localparam logic [VEL_W-1:0]         VEL_MIN    = 5'd5;
  localparam logic [VEL_W-1:0]         VEL_MAX    = 5'd20;
  localparam logic [VEL_W-1:0]         VEL_RESET  = 5'd10;
  localparam logic [BASE_W-1:0]        BASE_RESET = 7'd60;
  localparam logic [NOTE_W-1:0]        NOTE_MAX   = 8'd255;

  typedef struct packed {
    logic                     en;
    logic [PITCH_W-1:0]       pitch;
    logic signed [OCT_W-1:0]  octave;
    logic [VEL_W-1:0]         vel;
  } cell_t;

  localparam cell_t CELL_RESET = '{en: 1'b0, pitch: '0, octave: '0, vel: VEL_RESET};

  // Saturating raise or lower of the parameter picked by the edit mode.
  function automatic cell_t adjust(cell_t c, logic [MODE_W-1:0] mode, logic up);
    cell_t r;
    r = c;
    unique case (mode)
      MODE_PITCH: begin
        if (up && c.pitch < PITCH_MAX) r.pitch = c.pitch + 4'd1;
        else if (!up && c.pitch != '0) r.pitch = c.pitch - 4'd1;
      end
      MODE_OCTAVE: begin
        if (up && c.octave < OCT_MAX) r.octave = c.octave + 4'sd1;
        else if (!up && c.octave > OCT_MIN) r.octave = c.octave - 4'sd1;
      end
      MODE_VELOCITY: begin
        if (up && c.vel < VEL_MAX) r.vel = c.vel + 5'd1;
        else if (!up && c.vel > VEL_MIN) r.vel = c.vel - 5'd1;
      end
      default: r = c;
    endcase
    return r;
  endfunction

  // base + pitch + 12 * octave, clamped to the note range.
  function automatic logic [NOTE_W-1:0] note_of(logic [BASE_W-1:0] base, cell_t c);
    logic signed [SUM_W-1:0] oct_x;
    logic signed [SUM_W-1:0] sum;
    logic [NOTE_W-1:0]       r;
    oct_x = {{(SUM_W-OCT_W){c.octave[OCT_W-1]}}, c.octave};
    sum   = $signed({3'b000, base}) + $signed({6'b000000, c.pitch})
          + (oct_x <<< 3) + (oct_x <<< 2);
    if (sum < 0) r = '0;
    else if (sum > $signed(10'd255)) r = NOTE_MAX;
    else r = sum[NOTE_W-1:0];
    return r;
  endfunction

endpackage

// ===== hdl/mtss_cell_mem.sv =====
// Pattern cell memory: one write port, one read port, registered read data.
// Per-entry valid bits stand in for the reset contents. Uses mtss_pkg.

module mtss_cell_mem #(
  parameter int CELLS  = mtss_pkg::TRACKS_DEF * mtss_pkg::STEPS_DEF,
  parameter int CELL_W = $clog2(CELLS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [CELL_W-1:0]   rd_addr,
  output mtss_pkg::cell_t     rd_data,
  input  logic                wr_en,
  input  logic [CELL_W-1:0]   wr_addr,
  input  mtss_pkg::cell_t     wr_data
);

  mtss_pkg::cell_t mem [CELLS];
  logic [CELLS-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // forward a same-edge write; an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) rd_data <= wr_data;
      else if (vld[rd_addr]) rd_data <= mem[rd_addr];
      else rd_data <= mtss_pkg::CELL_RESET;
    end
  end

endmodule

// ===== hdl/mtss_ctrl.sv =====
// Command sequencer: edit state, read-modify-write of cells, play scan and
// the output word register. Uses mtss_pkg; drives mtss_cell_mem ports.

module mtss_ctrl #(
  parameter int TRACKS = mtss_pkg::TRACKS_DEF,
  parameter int STEPS  = mtss_pkg::STEPS_DEF,
  parameter int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1,
  parameter int CELL_W = $clog2(TRACKS * STEPS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtss_pkg::BASE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mtss_pkg::CMD_W-1:0]    command,
  input  logic [mtss_pkg::IDX_W-1:0]    step_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [TRK_W-1:0]              track,
  output logic [mtss_pkg::NOTE_W-1:0]   note_number,
  output logic [mtss_pkg::VEL_W-1:0]    velocity_level,
  output logic                          last,
  output logic                          rd_en,
  output logic [CELL_W-1:0]             rd_addr,
  input  mtss_pkg::cell_t               rd_data,
  output logic                          wr_en,
  output logic [CELL_W-1:0]             wr_addr,
  output mtss_pkg::cell_t               wr_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RMW   = 2'd1;
  localparam logic [1:0] S_PLAY  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam logic [TRK_W-1:0] TRK_LAST = TRK_W'(TRACKS - 1);

  logic [1:0]                    state;
  logic [TRK_W-1:0]              current_track;
  logic [mtss_pkg::MODE_W-1:0]   edit_mode;
  logic [mtss_pkg::IDX_W-1:0]    selected_step;
  logic                          selection_valid;
  logic [mtss_pkg::BASE_W-1:0]   base_note;
  logic [mtss_pkg::CMD_W-1:0]    cmd_r;
  logic [mtss_pkg::IDX_W-1:0]    idx_r;
  logic [CELL_W-1:0]             addr_r;
  logic [TRK_W-1:0]              cur_t;
  logic                          pend_valid;
  logic [TRK_W-1:0]              pend_track;
  logic [mtss_pkg::NOTE_W-1:0]   pend_note;
  logic [mtss_pkg::VEL_W-1:0]    pend_vel;

  logic in_fire, idx_ok, sel_ok, out_free, hit, stall, take_new, push_mid, push_last;
  logic scan_more;

  function automatic logic [CELL_W-1:0] cell_addr(logic [TRK_W-1:0] t,
                                                 logic [mtss_pkg::IDX_W-1:0] s);
    return CELL_W'(CELL_W'(t) * STEPS) + CELL_W'(s);
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign idx_ok    = int'(step_index) < STEPS;
  assign sel_ok    = selection_valid && (int'(selected_step) < STEPS);
  assign out_free  = !out_valid || out_ready;
  assign hit       = rd_data.en;
  assign stall     = (state == S_PLAY) && hit && pend_valid && !out_free;
  assign take_new  = (state == S_PLAY) && hit && !stall;
  assign push_mid  = (state == S_PLAY) && hit && pend_valid && out_free;
  assign push_last = (state == S_FLUSH) && pend_valid && out_free;
  assign scan_more = (state == S_PLAY) && !stall && (cur_t != TRK_LAST);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cell_addr(cur_t + TRK_W'(1), idx_r);
    if (in_fire) begin
      priority case (command)
        mtss_pkg::CMD_TOGGLE: begin
          rd_en   = sel_ok;
          rd_addr = cell_addr(current_track, selected_step);
        end
        mtss_pkg::CMD_INC, mtss_pkg::CMD_DEC: begin
          rd_en   = idx_ok;
          rd_addr = cell_addr(current_track, step_index);
        end
        mtss_pkg::CMD_PLAY: begin
          rd_en   = idx_ok;
          rd_addr = cell_addr('0, step_index);
        end
        default: rd_en = 1'b0;
      endcase
    end else if (scan_more) begin
      rd_en = 1'b1;
    end
  end

  assign wr_en   = (state == S_RMW);
  assign wr_addr = addr_r;
  always_comb begin
    wr_data = rd_data;
    if (cmd_r == mtss_pkg::CMD_TOGGLE) wr_data.en = !rd_data.en;
    else wr_data = mtss_pkg::adjust(rd_data, edit_mode, cmd_r == mtss_pkg::CMD_INC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_note <= mtss_pkg::BASE_RESET;
    end else if (cfg_we) begin
      base_note <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_track   <= '0;
      edit_mode       <= mtss_pkg::MODE_PITCH;
      selected_step   <= '0;
      selection_valid <= 1'b0;
      cur_t           <= '0;
      pend_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            priority case (command)
              mtss_pkg::CMD_SELECT: begin
                if (idx_ok) begin
                  selected_step   <= step_index;
                  selection_valid <= 1'b1;
                end
              end
              mtss_pkg::CMD_TOGGLE: if (sel_ok) state <= S_RMW;
              mtss_pkg::CMD_INC, mtss_pkg::CMD_DEC: if (idx_ok) state <= S_RMW;
              mtss_pkg::CMD_NEXT_TRK:
                current_track <= (current_track == TRK_LAST) ? '0
                                 : current_track + TRK_W'(1);
              mtss_pkg::CMD_PREV_TRK:
                current_track <= (current_track == '0) ? TRK_LAST
                                 : current_track - TRK_W'(1);
              mtss_pkg::CMD_NEXT_MODE:
                edit_mode <= (edit_mode == mtss_pkg::MODE_PITCH)  ? mtss_pkg::MODE_OCTAVE
                           : (edit_mode == mtss_pkg::MODE_OCTAVE) ? mtss_pkg::MODE_VELOCITY
                           : mtss_pkg::MODE_PITCH;
              mtss_pkg::CMD_PREV_MODE:
                edit_mode <= (edit_mode == mtss_pkg::MODE_PITCH)    ? mtss_pkg::MODE_VELOCITY
                           : (edit_mode == mtss_pkg::MODE_VELOCITY) ? mtss_pkg::MODE_OCTAVE
                           : mtss_pkg::MODE_PITCH;
              mtss_pkg::CMD_PLAY: begin
                if (idx_ok) begin
                  state <= S_PLAY;
                  cur_t <= '0;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RMW: state <= S_IDLE;
        S_PLAY: begin
          if (push_mid) out_valid <= 1'b1;
          if (take_new) pend_valid <= 1'b1;
          if (!stall) begin
            if (cur_t == TRK_LAST) state <= S_FLUSH;
            else cur_t <= cur_t + TRK_W'(1);
          end
        end
        S_FLUSH: begin
          if (push_last) begin
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end else if (!pend_valid) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= command;
      idx_r  <= step_index;
      addr_r <= rd_addr;
    end
    if (push_mid || push_last) begin
      track          <= pend_track;
      note_number    <= pend_note;
      velocity_level <= pend_vel;
      last           <= push_last;
    end
    if (take_new) begin
      pend_track <= cur_t;
      pend_note  <= mtss_pkg::note_of(base_note, rd_data);
      pend_vel   <= rd_data.vel;
    end
  end

`ifndef SYNTH
  a_pend_in_play: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_PLAY || state == S_FLUSH))
    else $error("held note outside a play scan");

  a_rmw_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |=> state == S_IDLE)
    else $error("write-back did not return to idle");

  a_play_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == mtss_pkg::CMD_PLAY && idx_ok) |=> (state == S_PLAY && cur_t == '0))
    else $error("play did not start at the first track");

  a_track_range: assert property (@(posedge clk) disable iff (rst)
    current_track <= TRK_LAST && cur_t <= TRK_LAST)
    else $error("track counter out of range");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    edit_mode <= mtss_pkg::MODE_VELOCITY)
    else $error("edit mode reached the unused code");
`endif

endmodule

// ===== hdl/multitrack_step_sequencer.sv =====
// Multitrack step sequencer top level: pattern cell memory and command sequencer.
// Uses mtss_pkg, mtss_cell_mem and mtss_ctrl.

// The pattern of TRACKS x STEPS cells (enable, pitch, octave, velocity) lives in
// one memory with a single read port and registered read data. Select, track and
// mode commands need no memory access; toggle, increment and decrement read the
// cell, then write it back. A play command scans the tracks one memory read per
// cycle while the output is not stalled and returns through a flush state to
// accept the next word. Each note is held until the next enabled track is found
// so that last can be flagged; a finished note waits in the output register while
// the next command is accepted. The user must write base_note via cfg_we/cfg_data
// only while idle; the block does not enforce it. No clearing pass follows reset.

module multitrack_step_sequencer #(
  parameter int TRACKS = mtss_pkg::TRACKS_DEF,
  parameter int STEPS  = mtss_pkg::STEPS_DEF,
  parameter int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mtss_pkg::BASE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mtss_pkg::CMD_W-1:0]    command,
  input  logic [mtss_pkg::IDX_W-1:0]    step_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [TRK_W-1:0]              track,
  output logic [mtss_pkg::NOTE_W-1:0]   note_number,
  output logic [mtss_pkg::VEL_W-1:0]    velocity_level,
  output logic                          last
);

  localparam int CELLS  = TRACKS * STEPS;
  localparam int CELL_W = $clog2(CELLS);

  logic              rd_en, wr_en;
  logic [CELL_W-1:0] rd_addr, wr_addr;
  mtss_pkg::cell_t   rd_data, wr_data;

  mtss_cell_mem #(
    .CELLS  (CELLS),
    .CELL_W (CELL_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mtss_ctrl #(
    .TRACKS (TRACKS),
    .STEPS  (STEPS),
    .TRK_W  (TRK_W),
    .CELL_W (CELL_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .step_index     (step_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .track          (track),
    .note_number    (note_number),
    .velocity_level (velocity_level),
    .last           (last),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

endmodule
